>>> hw/rtl/flat_window_max_sum_defines.svh
// Assertion macros used by the flat window search top level.
`ifndef FLAT_WINDOW_MAX_SUM_DEFINES_SVH
`define FLAT_WINDOW_MAX_SUM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FWMS_ASSERT_SAME(name, clk_s, rst_s, pre, post, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FWMS_ASSERT_NEXT(name, clk_s, rst_s, pre, post, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/fwms_pkg.sv
// Types and constants of the flat window search block.
package fwms_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int HEIGHT_BITS    = 16;
  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_ROWS       = 1024;
  localparam int WIN_SIZE       = 3;
  localparam int WIN_TAPS       = WIN_SIZE * WIN_SIZE;
  localparam int LINES          = WIN_SIZE - 1;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int ROW_BITS       = $clog2(MAX_ROWS);
  localparam int DIM_BITS       = 11;
  localparam int MIN_DIM        = 3;
  localparam int LIMIT_BITS     = 16;
  localparam int SUM_BITS       = SAMPLE_BITS + 4;
  localparam int OUT_SUM_BITS   = 20;
  localparam int LINE_WORD_BITS = LINES * SAMPLE_BITS;
  localparam int CMP_BITS       = 32;

  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_ADDR_BITS  = 4;
  localparam int REG_IDX_BITS   = CFG_ADDR_BITS - 2;

  localparam logic [REG_IDX_BITS-1:0] REG_FLATNESS_LIMIT = REG_IDX_BITS'(0);
  localparam logic [REG_IDX_BITS-1:0] REG_FRAME_WIDTH    = REG_IDX_BITS'(1);
  localparam logic [REG_IDX_BITS-1:0] REG_FRAME_HEIGHT   = REG_IDX_BITS'(2);

  typedef logic [SAMPLE_BITS-1:0]    sample_t;
  typedef logic [HEIGHT_BITS-1:0]    height_t;
  typedef logic [SUM_BITS-1:0]       sum_t;
  typedef logic [OUT_SUM_BITS-1:0]   out_sum_t;
  typedef logic [DIM_BITS-1:0]       dim_t;
  typedef logic [COL_BITS-1:0]       col_t;
  typedef logic [ROW_BITS-1:0]       row_t;
  typedef logic [LIMIT_BITS-1:0]     limit_t;
  typedef logic [LINE_WORD_BITS-1:0] line_word_t;

  typedef struct packed {
    sum_t    sum;
    sample_t mx;
    sample_t mn;
  } win_stats_t;

endpackage

>>> hw/rtl/fwms_in_if.sv
// Sample request channel of the flat window search block.
interface fwms_in_if import fwms_pkg::*; ();
  logic    valid;
  logic    ready;
  height_t height_sample;

  modport source (output valid, output height_sample, input ready);
  modport sink (input valid, input height_sample, output ready);
endinterface

>>> hw/rtl/fwms_out_if.sv
// Result request channel of the flat window search block.
interface fwms_out_if import fwms_pkg::*; ();
  logic     valid;
  logic     ready;
  out_sum_t best_sum;
  logic     found;

  modport source (output valid, output best_sum, output found, input ready);
  modport sink (input valid, input best_sum, input found, output ready);
endinterface

>>> hw/rtl/flat_window_max_sum.sv
// Top level of the flat 3x3 window search over a raster height map.
// The block takes one height sample per clock in raster order and keeps the
// two previous rows in a 1024 x 32-bit line store RAM with a registered read,
// which needs no clearing pass after reset. Each sample passes a four-stage
// pipeline (line store read, window shift, window statistics, best-sum
// update), so a frame's result enters the output register as its last sample
// completes the best-sum update. Input is refused only while a finished
// result waits in the output register and the next frame's last sample has
// reached the last stage. Frame width and height are clamped to 3..1024, and
// configuration should be written only while no sample is in flight.
`include "flat_window_max_sum_defines.svh"

module flat_window_max_sum import fwms_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  fwms_in_if.sink                  in_ch,
  fwms_out_if.source               out_ch,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  localparam dim_t MIN_DIM_V   = DIM_BITS'(MIN_DIM);
  localparam dim_t MAX_WIDTH_V = DIM_BITS'(MAX_WIDTH);
  localparam dim_t MAX_ROWS_V  = DIM_BITS'(MAX_ROWS);
  localparam col_t WIN_EDGE_C  = COL_BITS'(WIN_SIZE - 1);
  localparam row_t WIN_EDGE_R  = ROW_BITS'(WIN_SIZE - 1);

  limit_t limit_r;
  dim_t   width_r;
  dim_t   height_r;
  logic   cfg_we;
  logic [REG_IDX_BITS-1:0] cfg_idx;

  dim_t   width_use;
  dim_t   height_use;
  col_t   col_r;
  col_t   col_nxt;
  row_t   row_r;
  row_t   row_nxt;
  logic   last_col;
  logic   last_row;
  logic   adv;
  logic   in_accept;
  sample_t in_sample;

  logic    va_r;
  sample_t s_a_r;
  col_t    col_a_r;
  logic    win_a_r;
  logic    last_a_r;

  logic    vb_r;
  logic    win_b_r;
  logic    last_b_r;
  sample_t win_r [WIN_TAPS];

  logic       vc_r;
  logic       win_c_r;
  logic       last_c_r;
  win_stats_t stats;
  win_stats_t stats_c_r;

  logic       ram_we;
  logic       ram_re;
  col_t       ram_waddr;
  col_t       ram_raddr;
  line_word_t ram_wdata;
  line_word_t ram_rdata;
  sample_t    top_s;
  sample_t    mid_s;

  logic    d_fire;
  logic    qual;
  logic    take;
  sum_t    best_r;
  sum_t    best_upd;
  logic    any_found_r;
  logic    any_upd;
  logic    out_valid_r;
  out_sum_t out_best_sum_r;
  logic    out_found_r;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= '0;
      width_r  <= MAX_WIDTH_V;
      height_r <= MAX_ROWS_V;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FLATNESS_LIMIT: limit_r  <= cfg_pwdata[LIMIT_BITS-1:0];
        REG_FRAME_WIDTH:    width_r  <= cfg_pwdata[DIM_BITS-1:0];
        REG_FRAME_HEIGHT:   height_r <= cfg_pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FLATNESS_LIMIT: cfg_prdata = CFG_DATA_BITS'(limit_r);
      REG_FRAME_WIDTH:    cfg_prdata = CFG_DATA_BITS'(width_r);
      REG_FRAME_HEIGHT:   cfg_prdata = CFG_DATA_BITS'(height_r);
      default:            cfg_prdata = '0;
    endcase
  end

  // Frame position counters.
  always_comb begin
    if (width_r < MIN_DIM_V) begin
      width_use = MIN_DIM_V;
    end else if (width_r > MAX_WIDTH_V) begin
      width_use = MAX_WIDTH_V;
    end else begin
      width_use = width_r;
    end
    if (height_r < MIN_DIM_V) begin
      height_use = MIN_DIM_V;
    end else if (height_r > MAX_ROWS_V) begin
      height_use = MAX_ROWS_V;
    end else begin
      height_use = height_r;
    end
  end

  assign adv       = !(vc_r && last_c_r && out_valid_r);
  assign in_ch.ready = adv;
  assign in_accept = in_ch.valid && adv;
  assign in_sample = in_ch.height_sample[SAMPLE_BITS-1:0];
  assign last_col  = (DIM_BITS'(col_r) + DIM_BITS'(1)) >= width_use;
  assign last_row  = (DIM_BITS'(row_r) + DIM_BITS'(1)) >= height_use;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_accept) begin
      priority if (last_col && last_row) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_BITS'(1);
      end else begin
        col_nxt = col_r + COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line store holds the row above in the upper half and the newest row below.
  assign ram_re    = in_accept;
  assign ram_raddr = col_r;
  assign ram_we    = adv && va_r;
  assign ram_waddr = col_a_r;
  assign top_s     = ram_rdata[LINE_WORD_BITS-1:SAMPLE_BITS];
  assign mid_s     = ram_rdata[SAMPLE_BITS-1:0];
  assign ram_wdata = {mid_s, s_a_r};

  fwms_ram #(
    .WIDTH(LINE_WORD_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  fwms_win_stats u_win_stats (
    .win  (win_r),
    .stats(stats)
  );

  // Pipeline valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_accept;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s_a_r    <= in_sample;
      col_a_r  <= col_r;
      win_a_r  <= (row_r >= WIN_EDGE_R) && (col_r >= WIN_EDGE_C);
      last_a_r <= last_col && last_row;
    end
    if (adv && va_r) begin
      for (int r = 0; r < WIN_SIZE; r++) begin
        win_r[r*WIN_SIZE]   <= win_r[r*WIN_SIZE+1];
        win_r[r*WIN_SIZE+1] <= win_r[r*WIN_SIZE+2];
      end
      win_r[WIN_SIZE-1]          <= top_s;
      win_r[2*WIN_SIZE-1]        <= mid_s;
      win_r[WIN_TAPS-1]          <= s_a_r;
      win_b_r  <= win_a_r;
      last_b_r <= last_a_r;
    end
    if (adv && vb_r) begin
      stats_c_r <= stats;
      win_c_r   <= win_b_r;
      last_c_r  <= last_b_r;
    end
  end

  // Best sum tracking and result register.
  assign d_fire   = adv && vc_r;
  assign qual     = win_c_r
                 && (CMP_BITS'(stats_c_r.mx - stats_c_r.mn) <= CMP_BITS'(limit_r));
  assign take     = qual && (!any_found_r || (stats_c_r.sum > best_r));
  assign best_upd = take ? stats_c_r.sum : best_r;
  assign any_upd  = any_found_r || qual;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r      <= '0;
      any_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (d_fire) begin
        if (last_c_r) begin
          best_r      <= '0;
          any_found_r <= 1'b0;
        end else begin
          best_r      <= best_upd;
          any_found_r <= any_upd;
        end
      end
      if (d_fire && last_c_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_fire && last_c_r) begin
      out_best_sum_r <= any_upd ? OUT_SUM_BITS'(best_upd) : '0;
      out_found_r    <= any_upd;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.best_sum = out_best_sum_r;
  assign out_ch.found    = out_found_r;

  `FWMS_ASSERT_SAME(a_line_store_no_collide, clk, rst_n, ram_we && ram_re, ram_waddr != ram_raddr, "Line store read and write hit the same column.")
  `FWMS_ASSERT_SAME(a_empty_result_zero, clk, rst_n, out_valid_r && !out_found_r, out_best_sum_r == '0, "Result without a flat window carries a nonzero sum.")
  `FWMS_ASSERT_NEXT(a_frame_end_result, clk, rst_n, d_fire && last_c_r, out_valid_r, "Frame end did not load a result.")
  `FWMS_ASSERT_NEXT(a_frame_end_clears, clk, rst_n, d_fire && last_c_r, !any_found_r && best_r == '0, "Best sum was not cleared at frame end.")

endmodule

>>> hw/rtl/fwms_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module fwms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/fwms_win_stats.sv
// Sum, maximum and minimum of the nine samples of a 3x3 window.
module fwms_win_stats import fwms_pkg::*; (
  input  sample_t    win [WIN_TAPS],
  output win_stats_t stats
);

  function automatic sample_t max3(sample_t a, sample_t b, sample_t c);
    sample_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic sample_t min3(sample_t a, sample_t b, sample_t c);
    sample_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  sum_t    row_sum [WIN_SIZE];
  sample_t row_max [WIN_SIZE];
  sample_t row_min [WIN_SIZE];

  always_comb begin
    for (int r = 0; r < WIN_SIZE; r++) begin
      row_sum[r] = sum_t'(win[r*WIN_SIZE]) + sum_t'(win[r*WIN_SIZE+1])
                 + sum_t'(win[r*WIN_SIZE+2]);
      row_max[r] = max3(win[r*WIN_SIZE], win[r*WIN_SIZE+1], win[r*WIN_SIZE+2]);
      row_min[r] = min3(win[r*WIN_SIZE], win[r*WIN_SIZE+1], win[r*WIN_SIZE+2]);
    end
    stats.sum = row_sum[0] + row_sum[1] + row_sum[2];
    stats.mx  = max3(row_max[0], row_max[1], row_max[2]);
    stats.mn  = min3(row_min[0], row_min[1], row_min[2]);
  end

endmodule
